/* design/kmer_overlap_row_matcher_assert.svh */
// assertion macros for the k-mer overlap row matcher
// every property is sampled on clk and disabled while rst_n is low
`ifndef KMER_OVERLAP_ROW_MATCHER_ASSERT_SVH
`define KMER_OVERLAP_ROW_MATCHER_ASSERT_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define KOR_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define KOR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define KOR_ASSERT_NOW(label, ante, cons, msg)

`define KOR_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* design/kor_pkg.sv */
package kor_pkg;

    localparam int KMER_W    = 64;
    localparam int LEN_W     = 6;
    localparam int IDX_W     = 6;
    localparam int CMD_W     = 2;
    localparam int NUC_BITS  = 2;
    localparam int WORD_NUCS = 32;

    localparam logic [LEN_W-1:0] KMER_LEN_RESET = 6'd31;

    typedef enum logic [CMD_W-1:0] {
        CMD_LOAD  = 2'd0,
        CMD_CLEAR = 2'd1,
        CMD_ROW   = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEEK,
        ST_SCAN
    } state_t;

    // per-cell control coming from the sequencer
    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctl_t;

    // mask of the k-1 leading nucleotides that take part in the overlap check
    function automatic logic [KMER_W-1:0] overlap_mask(input logic [LEN_W-1:0] len);
        logic [4:0]        n;
        logic [KMER_W-1:0] m;
        m = '0;
        if (len > LEN_W'(WORD_NUCS))
        begin
            n = 5'(WORD_NUCS - 1);
        end
        else if (len == '0)
        begin
            n = '0;
        end
        else
        begin
            n = 5'(len - 1'b1);
        end
        for (int i = 0; i < WORD_NUCS; i++)
        begin
            if (i < int'(n))
            begin
                m[i*NUC_BITS +: NUC_BITS] = '1;
            end
        end
        return m;
    endfunction

endpackage

/* design/kmer_overlap_row_matcher.sv */
// k-mer overlap row matcher
//
// command channel: start with command, kmer_word and ref_index; a command is
// transferred at a rising edge with start high and busy low
// load appends kmer_word to the table (ignored once MAX_READS reads are held),
// clear empties it; neither raises busy nor gives a result
// a row command turns the ring of table cells twice: one turn picks up the
// reference k-mer at the head cell, a second turn compares it with every
// read in table order
// busy stays high through both turns; the results come from the second turn
// through the result registers, one result per cycle
// a bad reference index (not below the stored count, or an empty table)
// gives a single error result in the cycle after the transfer
// results: result_valid strobes for one cycle per result; the receiver
// cannot stall, so every result is taken in the cycle it is shown
// config channel: cfg_valid/cfg_ready carry kmer_length; always ready; the user
// must see that it is written only while the block is idle, the block does not enforce it
// reset clears the read count, sets the compare mask for a kmer_length of 31 and
// drops any row; table contents are kept as they are and are unread until loaded again
`include "kmer_overlap_row_matcher_assert.svh"

module kmer_overlap_row_matcher #(
    parameter int MAX_READS = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    // command channel
    input  logic                        start,
    output logic                        busy,
    input  logic [kor_pkg::CMD_W-1:0]   command,
    input  logic [kor_pkg::KMER_W-1:0]  kmer_word,
    input  logic [kor_pkg::IDX_W-1:0]   ref_index,
    // config channel
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [kor_pkg::LEN_W-1:0]   kmer_length,
    // result strobe and payload
    output logic                        result_valid,
    output logic [kor_pkg::IDX_W-1:0]   read_index,
    output logic                        overlaps,
    output logic                        last,
    output logic                        bad_request
);

    localparam int STEP_W = $clog2(MAX_READS);
    localparam int CNT_W  = $clog2(MAX_READS + 1);
    localparam int CMP_W  = (CNT_W > kor_pkg::IDX_W) ? CNT_W : kor_pkg::IDX_W;

    // sequencer state
    kor_pkg::state_t            state_reg;
    kor_pkg::state_t            state_next;
    logic [STEP_W-1:0]          step_reg;
    logic [STEP_W-1:0]          step_next;
    logic [CNT_W-1:0]           count_reg;
    logic [CNT_W-1:0]           count_next;
    logic [kor_pkg::KMER_W-1:0] mask_reg;
    logic [kor_pkg::IDX_W-1:0]  ref_idx_reg;
    logic [kor_pkg::KMER_W-1:0] ref_word_reg;

    // result registers
    logic                       result_valid_reg;
    logic                       result_valid_next;
    logic [kor_pkg::IDX_W-1:0]  read_index_reg;
    logic [kor_pkg::IDX_W-1:0]  read_index_next;
    logic                       overlaps_reg;
    logic                       overlaps_next;
    logic                       last_reg;
    logic                       last_next;
    logic                       bad_request_reg;
    logic                       bad_request_next;

    // control
    logic                       cmd_fire;
    logic                       load_fire;
    logic                       row_go;
    logic                       row_bad;
    logic                       step_end;
    logic                       ring_shift;
    logic                       ref_capture;
    logic                       emit;
    logic                       hit;

    // ring of table cells, head at cell 0
    logic [kor_pkg::KMER_W-1:0] cell_word [MAX_READS];

    assign cfg_ready = 1'b1;

    assign cmd_fire  = start && !busy;
    assign load_fire = cmd_fire && (command == kor_pkg::CMD_LOAD)
                       && (count_reg != CNT_W'(MAX_READS));
    assign row_bad   = CMP_W'(ref_index) >= CMP_W'(count_reg);
    assign row_go    = cmd_fire && (command == kor_pkg::CMD_ROW) && !row_bad;
    assign step_end  = step_reg == STEP_W'(MAX_READS - 1);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            kor_pkg::ST_IDLE:
            begin
                if (row_go)
                begin
                    state_next = kor_pkg::ST_SEEK;
                end
            end
            kor_pkg::ST_SEEK:
            begin
                if (step_end)
                begin
                    state_next = kor_pkg::ST_SCAN;
                end
            end
            kor_pkg::ST_SCAN:
            begin
                if (step_end)
                begin
                    state_next = kor_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = kor_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        busy        = 1'b0;
        ring_shift  = 1'b0;
        ref_capture = 1'b0;
        emit        = 1'b0;
        case (state_reg)
            kor_pkg::ST_IDLE:
            begin
                busy = 1'b0;
            end
            kor_pkg::ST_SEEK:
            begin
                busy        = 1'b1;
                ring_shift  = 1'b1;
                // the head cell holds entry step during the turn
                ref_capture = CMP_W'(step_reg) == CMP_W'(ref_idx_reg);
            end
            kor_pkg::ST_SCAN:
            begin
                busy       = 1'b1;
                ring_shift = 1'b1;
                emit       = CNT_W'(step_reg) < count_reg;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

    // step counter follows the ring position, zero while idle
    always_comb
    begin
        step_next = '0;
        if (ring_shift && !step_end)
        begin
            step_next = step_reg + 1'b1;
        end
    end

    // read count
    always_comb
    begin
        count_next = count_reg;
        if (cmd_fire)
        begin
            case (command)
                kor_pkg::CMD_LOAD:
                begin
                    if (load_fire)
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                kor_pkg::CMD_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    // reference suffix against the read prefix at the head cell; the reference's own entry always hits
    assign hit = (CMP_W'(step_reg) == CMP_W'(ref_idx_reg))
                 || ((((ref_word_reg >> kor_pkg::NUC_BITS) ^ cell_word[0]) & mask_reg) == '0);

    // result register load
    always_comb
    begin
        result_valid_next = 1'b0;
        read_index_next   = read_index_reg;
        overlaps_next     = overlaps_reg;
        last_next         = last_reg;
        bad_request_next  = bad_request_reg;
        if (emit)
        begin
            result_valid_next = 1'b1;
            read_index_next   = kor_pkg::IDX_W'(step_reg);
            overlaps_next     = hit;
            last_next         = (CNT_W'(step_reg) + CNT_W'(1)) == count_reg;
            bad_request_next  = 1'b0;
        end
        else if (cmd_fire && (command == kor_pkg::CMD_ROW) && row_bad)
        begin
            result_valid_next = 1'b1;
            read_index_next   = ref_index;
            overlaps_next     = 1'b0;
            last_next         = 1'b1;
            bad_request_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= kor_pkg::ST_IDLE;
            step_reg         <= '0;
            count_reg        <= '0;
            mask_reg         <= kor_pkg::overlap_mask(kor_pkg::KMER_LEN_RESET);
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            step_reg         <= step_next;
            count_reg        <= count_next;
            result_valid_reg <= result_valid_next;
            // config transfer: keep the compare mask rather than the raw length
            if (cfg_valid && cfg_ready)
            begin
                mask_reg <= kor_pkg::overlap_mask(kmer_length);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_go)
        begin
            ref_idx_reg <= ref_index;
        end
        if (ref_capture)
        begin
            ref_word_reg <= cell_word[0];
        end
        read_index_reg  <= read_index_next;
        overlaps_reg    <= overlaps_next;
        last_reg        <= last_next;
        bad_request_reg <= bad_request_next;
    end

    // the cell ring: each cell takes its upper neighbor's word as the ring turns
    for (genvar g = 0; g < MAX_READS; g++)
    begin : g_cell
        localparam int Nxt = (g + 1) % MAX_READS;
        kor_pkg::cell_ctl_t ctl;

        assign ctl.shift = ring_shift;
        assign ctl.load  = load_fire && (count_reg == CNT_W'(g));

        kor_cell u_cell (
            .clk       (clk),
            .ctl       (ctl),
            .load_word (kmer_word),
            .next_word (cell_word[Nxt]),
            .word      (cell_word[g])
        );
    end

    assign result_valid = result_valid_reg;
    assign read_index   = read_index_reg;
    assign overlaps     = overlaps_reg;
    assign last         = last_reg;
    assign bad_request  = bad_request_reg;

    // error results are single and never claim an overlap
    `KOR_ASSERT_NOW(a_err_shape, result_valid_reg && bad_request_reg,
        last_reg && !overlaps_reg, "error result must be last with no overlap")

    // the table never holds more than MAX_READS reads
    `KOR_ASSERT_NOW(a_count_bound, 1'b1, count_reg <= CNT_W'(MAX_READS),
        "read count above table size")

    // a row ends at its last result, nothing of it follows
    `KOR_ASSERT_NEXT(a_row_end, result_valid_reg && last_reg && !bad_request_reg,
        !(result_valid_reg && !bad_request_reg), "row result after last")

    // an accepted row command enters the seek turn with the step counter at zero
    `KOR_ASSERT_NEXT(a_row_start, row_go,
        (state_reg == kor_pkg::ST_SEEK) && (step_reg == '0), "row did not start seek")

endmodule

/* design/kor_cell.sv */
module kor_cell (
    input  logic                        clk,
    input  kor_pkg::cell_ctl_t          ctl,
    input  logic [kor_pkg::KMER_W-1:0]  load_word,
    input  logic [kor_pkg::KMER_W-1:0]  next_word,
    output logic [kor_pkg::KMER_W-1:0]  word
);

    logic [kor_pkg::KMER_W-1:0] word_reg;
    logic [kor_pkg::KMER_W-1:0] word_next;

    // load from the host or take the neighbor's word while the ring turns
    always_comb
    begin
        word_next = word_reg;
        if (ctl.load)
        begin
            word_next = load_word;
        end
        else if (ctl.shift)
        begin
            word_next = next_word;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    assign word = word_reg;

endmodule
